// ===== rtl/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants and control types of the RC4 engine.
// ----------------------------------------------------------------------------
package rc4_pkg;

	localparam int SBOX_DEPTH        = 256;
	localparam int ADDR_W            = $clog2(SBOX_DEPTH);
	localparam int BYTE_W            = 8;
	localparam int KEY_WORD_W        = 64;
	localparam int KEY_LEN_W         = 5;
	localparam int KEY_BYTES_HW      = 2 * KEY_WORD_W / BYTE_W;
	localparam int KEY_SEL_W         = $clog2(KEY_BYTES_HW);
	localparam int MAX_KEY_BYTES_DEF = 16;
	localparam int CFG_INDEX_W       = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH = 2'd2;

	localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;

	localparam logic OP_SCHEDULE = 1'b0;
	localparam logic OP_DATA     = 1'b1;

	typedef struct packed {
		logic start;
		logic start_sched;
		logic rd_x;
		logic rd_y;
		logic wr_x;
		logic wr_y;
		logic step;
		logic sched;
		logic load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic last_iter;
	} dp_status_t;

endpackage

// ===== rtl/rc4_stream_cipher_top.sv =====
// ----------------------------------------------------------------------------
// rc4_stream_cipher_top
// RC4 engine: key schedule and byte-wise encrypt/decrypt.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------
//   input    | in_valid / in_stall  | operation, data_in
//   output   | out_valid / out_stall| data_out, schedule_done
//   config   | cfg_write            | cfg_index, cfg_data
//
// Data item: after accept the states RD_X, RD_Y, WR_X and WR_Y run to the output
// register, and a new item is accepted only once the engine is back in idle; three
// dependent S-box reads through one registered read port set this. Schedule item: 256 rounds of those states.
// Reset: S-box reads as identity at once through per-entry valid bits.
// A stalled output only holds the engine once a second result is ready.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_top import rc4_pkg::*; #(
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [KEY_WORD_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   operation,
	input  logic [BYTE_W-1:0]      data_in,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [BYTE_W-1:0]      data_out,
	output logic                   schedule_done
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	rc4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	rc4_datapath #(
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.data_in       (data_in),
		.cmd           (cmd),
		.status        (status),
		.data_out      (data_out),
		.schedule_done (schedule_done)
	);

endmodule

// ===== rtl/rc4_sbox.sv =====
// ----------------------------------------------------------------------------
// rc4_sbox
// 256 x 8 S-box memory, one write and one registered read per cycle.
// Valid bits make an unwritten entry read as its own address.
// ----------------------------------------------------------------------------
module rc4_sbox import rc4_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0]     mem [SBOX_DEPTH];
	logic [SBOX_DEPTH-1:0] vld_q;
	logic [BYTE_W-1:0]     rd_q;
	logic [ADDR_W-1:0]     raddr_q;
	logic                  rvld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q    <= mem[rd_addr];
			raddr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
			if (clear) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rvld_q ? rd_q : BYTE_W'(raddr_q);

endmodule

// ===== rtl/rc4_datapath.sv =====
// ----------------------------------------------------------------------------
// rc4_datapath
// Key registers, index registers, S-box access and output register.
// ----------------------------------------------------------------------------
module rc4_datapath import rc4_pkg::*; #(
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [KEY_WORD_W-1:0]  cfg_data,
	input  logic [BYTE_W-1:0]      data_in,
	input  ctl_cmd_t               cmd,
	output dp_status_t             status,
	output logic [BYTE_W-1:0]      data_out,
	output logic                   schedule_done
);

	localparam int KPW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

	logic [KEY_WORD_W-1:0]   key_low_q;
	logic [KEY_WORD_W-1:0]   key_high_q;
	logic [KEY_LEN_W-1:0]    key_len_q;
	logic [ADDR_W-1:0]       i_q;
	logic [ADDR_W-1:0]       y_q;
	logic [KPW-1:0]          kpos_q;
	logic [BYTE_W-1:0]       a_q;
	logic [BYTE_W-1:0]       b_q;
	logic [ADDR_W-1:0]       t_q;
	logic [BYTE_W-1:0]       din_q;
	logic [BYTE_W-1:0]       data_out_q;
	logic                    schedule_done_q;

	logic [KEY_LEN_W-1:0]    used_len;
	logic [2*KEY_WORD_W-1:0] key_all;
	logic [KEY_SEL_W-1:0]    key_sel;
	logic [BYTE_W-1:0]       key_byte;
	logic [BYTE_W-1:0]       rd_val;
	logic [ADDR_W-1:0]       y_next;
	logic                    rd_en;
	logic [ADDR_W-1:0]       rd_addr;
	logic                    wr_en;
	logic [ADDR_W-1:0]       wr_addr;
	logic [BYTE_W-1:0]       wr_data;
	logic [BYTE_W-1:0]       keystream;

	always_comb begin
		if (key_len_q == '0) begin
			used_len = KEY_LEN_W'(1);
		end else if (key_len_q > MAX_LEN) begin
			used_len = MAX_LEN;
		end else begin
			used_len = key_len_q;
		end
	end

	assign key_all  = {key_high_q, key_low_q};
	assign key_sel  = KEY_SEL_W'(kpos_q);
	assign key_byte = key_all[{key_sel, 3'b000} +: BYTE_W];

	assign y_next = y_q + ADDR_W'(rd_val) + (cmd.sched ? ADDR_W'(key_byte) : '0);

	always_comb begin
		priority if (cmd.rd_y) begin
			rd_addr = y_next;
		end else if (cmd.wr_x) begin
			rd_addr = ADDR_W'(a_q + rd_val);
		end else begin
			rd_addr = i_q;
		end
	end

	assign rd_en   = cmd.rd_x | cmd.rd_y | cmd.wr_x;
	assign wr_en   = cmd.wr_x | cmd.wr_y;
	assign wr_addr = cmd.wr_y ? y_q : i_q;
	assign wr_data = cmd.wr_y ? a_q : rd_val;

	// the read of S[a+b] saw the memory before the swap
	always_comb begin
		priority if (t_q == y_q) begin
			keystream = a_q;
		end else if (t_q == i_q) begin
			keystream = b_q;
		end else begin
			keystream = rd_val;
		end
	end

	rc4_sbox u_sbox (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (cmd.start & cmd.start_sched),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_val)
	);

	assign status.last_iter = &i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			key_len_q  <= KEY_LEN_RESET;
			i_q        <= '0;
			y_q        <= '0;
			kpos_q     <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_KEY_LOW:    key_low_q  <= cfg_data;
					CFG_KEY_HIGH:   key_high_q <= cfg_data;
					CFG_KEY_LENGTH: key_len_q  <= cfg_data[KEY_LEN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.start) begin
				if (cmd.start_sched) begin
					i_q    <= '0;
					y_q    <= '0;
					kpos_q <= '0;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			if (cmd.rd_y) begin
				y_q <= y_next;
			end
			if (cmd.step && cmd.sched) begin
				i_q <= i_q + 1'b1;
				if (KEY_LEN_W'(kpos_q) + KEY_LEN_W'(1) >= used_len) begin
					kpos_q <= '0;
				end else begin
					kpos_q <= kpos_q + 1'b1;
				end
				if (status.last_iter) begin
					y_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			din_q <= data_in;
		end
		if (cmd.rd_y) begin
			a_q <= rd_val;
		end
		if (cmd.wr_x) begin
			b_q <= rd_val;
			t_q <= ADDR_W'(a_q + rd_val);
		end
		if (cmd.load_out) begin
			data_out_q      <= cmd.sched ? '0 : (din_q ^ keystream);
			schedule_done_q <= cmd.sched;
		end
	end

	assign data_out      = data_out_q;
	assign schedule_done = schedule_done_q;

endmodule

// ===== rtl/rc4_ctrl.sv =====
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for key schedule and data items, plus output valid.
// ----------------------------------------------------------------------------
module rc4_ctrl import rc4_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       operation,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t status,
	output ctl_cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_X,
		ST_RD_Y,
		ST_WR_X,
		ST_WR_Y,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic   op_q;
	logic   out_valid_q;
	logic   in_acc;
	logic   out_free;
	logic   finish;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign finish   = (state_q == ST_WR_Y) && ((op_q == OP_DATA) || status.last_iter);

	always_comb begin
		cmd.start       = in_acc;
		cmd.start_sched = (operation == OP_SCHEDULE);
		cmd.rd_x        = (state_q == ST_RD_X);
		cmd.rd_y        = (state_q == ST_RD_Y);
		cmd.wr_x        = (state_q == ST_WR_X);
		cmd.wr_y        = (state_q == ST_WR_Y);
		cmd.step        = (state_q == ST_WR_Y);
		cmd.sched       = (op_q == OP_SCHEDULE);
		cmd.load_out    = (finish || (state_q == ST_HOLD)) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_DATA;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.load_out || (out_valid_q && out_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q    <= operation;
						state_q <= ST_RD_X;
					end
				end
				ST_RD_X: state_q <= ST_RD_Y;
				ST_RD_Y: state_q <= ST_WR_X;
				ST_WR_X: state_q <= ST_WR_Y;
				ST_WR_Y: begin
					if (!finish) begin
						state_q <= ST_RD_X;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && out_stall))
		else $error("result overwrote a stalled output");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_RD_X))
		else $error("accepted item did not start");

	a_data_one_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR_Y && op_q == OP_DATA) |=>
		(state_q == ST_IDLE || state_q == ST_HOLD))
		else $error("data item looped");

	a_hold_keeps_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD && !out_free) |=> (state_q == ST_HOLD && out_valid_q))
		else $error("held result lost");

endmodule

// ===== verif/rc4_stream_cipher_top_tb.sv =====
// ----------------------------------------------------------------------------
// rc4_stream_cipher_top_tb
// Checks the RC4 engine against a cycle-free software copy of the cipher.
// Key schedule and data items are driven over the valid/stall input, keys
// are loaded between phases, and each output item is compared field by field
// in order. Covers the reset S-box, key length limits, an ignored register
// index, a long output hold-off and randomly keyed streams with random gaps.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_top_tb import rc4_pkg::*; ();

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 4;
	localparam int IDLE_LIMIT   = 8000;
	localparam int TAIL_CYCLES  = 1100;
	localparam int STREAM_ITEMS = 1000;
	localparam int HOLDOFF_LEN  = 300;

	localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;
	localparam logic [KEY_WORD_W-1:0]  KEY_ONES     = '1;
	localparam logic [KEY_WORD_W-1:0]  KEY_ZERO     = '0;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              done;
	} cipher_out_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_write     = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [KEY_WORD_W-1:0]  cfg_data      = '0;
	logic                   in_valid      = 1'b0;
	logic                   in_stall;
	logic                   operation     = OP_DATA;
	logic [BYTE_W-1:0]      data_in       = '0;
	logic                   out_valid;
	logic                   out_stall     = 1'b0;
	logic [BYTE_W-1:0]      data_out;
	logic                   schedule_done;

	// cipher state mirror
	logic [BYTE_W-1:0]     perm [0:SBOX_DEPTH-1];
	logic [BYTE_W-1:0]     ks_i;
	logic [BYTE_W-1:0]     ks_j;
	logic [KEY_WORD_W-1:0] key_word_lo;
	logic [KEY_WORD_W-1:0] key_word_hi;
	logic [KEY_LEN_W-1:0]  key_len;

	cipher_out_t expected_out [$];

	int mismatches  = 0;
	int idle_cycles = 0;
	int holdoff_req = 0;
	bit throttle    = 1'b0;

	rc4_stream_cipher_top #(
		.MAX_KEY_BYTES(MAX_KEY_BYTES_DEF)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.data_in      (data_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_out     (data_out),
		.schedule_done(schedule_done)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	function automatic void load_identity();
		for (int n = 0; n < SBOX_DEPTH; n++)
			perm[n] = BYTE_W'(n);
	endfunction

	function automatic void run_key_schedule();
		logic [BYTE_W-1:0]     acc;
		logic [BYTE_W-1:0]     a;
		logic [KEY_WORD_W-1:0] word;
		int                    len;
		int                    kpos;
		len = key_len;
		if (len == 0)
			len = 1;
		if (len > MAX_KEY_BYTES_DEF)
			len = MAX_KEY_BYTES_DEF;
		load_identity();
		acc  = '0;
		kpos = 0;
		for (int n = 0; n < SBOX_DEPTH; n++) begin
			a       = perm[n];
			word    = (kpos < 8) ? key_word_lo : key_word_hi;
			acc     = acc + a + word[8*(kpos%8) +: BYTE_W];
			perm[n] = perm[acc];
			perm[acc] = a;
			kpos    = (kpos + 1 >= len) ? 0 : kpos + 1;
		end
		ks_i = '0;
		ks_j = '0;
	endfunction

	function automatic logic [BYTE_W-1:0] next_key_byte();
		logic [BYTE_W-1:0] a;
		logic [BYTE_W-1:0] b;
		logic [BYTE_W-1:0] sel;
		ks_i       = ks_i + 1'b1;
		a          = perm[ks_i];
		ks_j       = ks_j + a;
		b          = perm[ks_j];
		perm[ks_i] = b;
		perm[ks_j] = a;
		sel        = a + b;
		return perm[sel];
	endfunction

	function automatic cipher_out_t predict_cipher(logic op, logic [BYTE_W-1:0] din);
		cipher_out_t r;
		if (op == OP_SCHEDULE) begin
			run_key_schedule();
			r.data = '0;
			r.done = 1'b1;
		end else begin
			r.data = din ^ next_key_byte();
			r.done = 1'b0;
		end
		return r;
	endfunction

	// mostly short, a few long
	function automatic int pick_stretch();
		if ($urandom_range(0, 9) != 0)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int pick_gap();
		if (!throttle || $urandom_range(0, 99) < 55)
			return 0;
		return pick_stretch();
	endfunction

	task automatic send_item(input logic op, input logic [BYTE_W-1:0] din);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		data_in   <= din;
		do @(posedge clk); while (!(in_valid && !in_stall));
		expected_out.push_back(predict_cipher(op, din));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_out.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_put(input logic [CFG_INDEX_W-1:0] idx,
			input logic [KEY_WORD_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_KEY_LOW:    key_word_lo = val;
			CFG_KEY_HIGH:   key_word_hi = val;
			CFG_KEY_LENGTH: key_len     = val[KEY_LEN_W-1:0];
			default:        ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_key(input logic [KEY_WORD_W-1:0] lo, input logic [KEY_WORD_W-1:0] hi,
			input logic [KEY_LEN_W-1:0] len);
		logic [KEY_WORD_W-1:0] len_word;
		len_word                 = {$urandom, $urandom};
		len_word[KEY_LEN_W-1:0]  = len;
		cfg_put(CFG_KEY_LOW, lo);
		cfg_put(CFG_KEY_HIGH, hi);
		cfg_put(CFG_KEY_LENGTH, len_word);
	endtask

	// data straight out of reset, then a schedule with the reset key
	task automatic test_unkeyed_stream();
		send_item(OP_DATA, 8'h00);
		send_item(OP_DATA, 8'hFF);
		send_item(OP_DATA, 8'h01);
		send_item(OP_DATA, 8'h80);
		send_item(OP_SCHEDULE, 8'hFF);
		send_item(OP_DATA, 8'h5A);
		send_item(OP_DATA, 8'hA5);
	endtask

	task automatic test_key_length_limits();
		// zero length acts as one byte
		wait_drained();
		load_key(KEY_ONES, KEY_ONES, 5'd0);
		send_item(OP_SCHEDULE, 8'h00);
		send_item(OP_DATA, 8'h00);
		send_item(OP_DATA, 8'hFF);
		// oversize length saturates
		wait_drained();
		load_key({$urandom, $urandom}, {$urandom, $urandom}, 5'd31);
		send_item(OP_SCHEDULE, 8'h00);
		send_item(OP_DATA, 8'hFF);
		send_item(OP_DATA, 8'h00);
		wait_drained();
		load_key(64'h0123456789ABCDEF, KEY_ZERO, 5'd1);
		send_item(OP_SCHEDULE, 8'h00);
		send_item(OP_DATA, 8'h3C);
		send_item(OP_DATA, 8'hC3);
		wait_drained();
		load_key(KEY_ONES, {$urandom, $urandom}, 5'd16);
		send_item(OP_SCHEDULE, 8'h00);
		send_item(OP_DATA, 8'h7F);
		send_item(OP_DATA, 8'h80);
		// unmapped index must not touch the key
		wait_drained();
		cfg_put(CFG_UNMAPPED, KEY_ONES);
		send_item(OP_SCHEDULE, 8'h00);
		send_item(OP_DATA, 8'hFF);
	endtask

	task automatic test_output_holdoff();
		wait_drained();
		throttle    = 1'b0;
		holdoff_req = HOLDOFF_LEN;
		repeat (24) send_item(OP_DATA, 8'($urandom));
		wait_drained();
		throttle = 1'b1;
	endtask

	task automatic test_random_streams();
		int                    sent;
		int                    burst;
		logic [KEY_WORD_W-1:0] lo;
		logic [KEY_WORD_W-1:0] hi;
		logic [KEY_LEN_W-1:0]  len;
		sent = 0;
		while (sent < STREAM_ITEMS) begin
			wait_drained();
			throttle = ($urandom_range(0, 4) != 0);
			// now and then keep running on the old key stream
			if ($urandom_range(0, 5) != 0) begin
				lo = {$urandom, $urandom};
				hi = {$urandom, $urandom};
				case ($urandom_range(0, 7))
					0: begin lo = KEY_ZERO; hi = KEY_ZERO; end
					1: begin lo = KEY_ONES; hi = KEY_ONES; end
					default: ;
				endcase
				case ($urandom_range(0, 9))
					0: len = 5'd0;
					1: len = KEY_LEN_W'($urandom_range(17, 31));
					2: len = 5'd1;
					3: len = 5'd16;
					default: len = KEY_LEN_W'($urandom_range(1, 16));
				endcase
				load_key(lo, hi, len);
				send_item(OP_SCHEDULE, 8'($urandom));
				sent++;
			end
			burst = $urandom_range(8, 60);
			repeat (burst) begin
				if ($urandom_range(0, 49) == 0)
					send_item(OP_SCHEDULE, 8'($urandom));
				else
					send_item(OP_DATA, 8'($urandom));
			end
			sent += burst;
		end
	endtask

	initial begin : out_stall_gen
		int span;
		@(posedge clk);
		forever begin
			if (holdoff_req > 0) begin
				span        = holdoff_req;
				holdoff_req = 0;
				out_stall  <= 1'b1;
			end else if (throttle && $urandom_range(0, 99) < 35) begin
				span       = pick_stretch();
				out_stall <= 1'b1;
			end else begin
				span       = throttle ? $urandom_range(1, 4) : 1;
				out_stall <= 1'b0;
			end
			repeat (span) @(posedge clk);
		end
	end

	always @(posedge clk) begin : check_results
		cipher_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_out.size() == 0) begin
				$display("%0t: unexpected item, data_out %02h schedule_done %b",
					$time, data_out, schedule_done);
				mismatches++;
			end else begin
				want = expected_out.pop_front();
				if (data_out !== want.data) begin
					$display("%0t: data_out expected %02h actual %02h",
						$time, want.data, data_out);
					mismatches++;
				end
				if (schedule_done !== want.done) begin
					$display("%0t: schedule_done expected %b actual %b",
						$time, want.done, schedule_done);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: timeout, %0d items outstanding", $time, expected_out.size());
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		load_identity();
		ks_i        = '0;
		ks_j        = '0;
		key_word_lo = '0;
		key_word_hi = '0;
		key_len     = KEY_LEN_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		throttle = 1'b1;
		test_unkeyed_stream();
		test_key_length_limits();
		test_output_holdoff();
		test_random_streams();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rc4_pkg.sv
rtl/rc4_sbox.sv
rtl/rc4_datapath.sv
rtl/rc4_ctrl.sv
rtl/rc4_stream_cipher_top.sv
verif/rc4_stream_cipher_top_tb.sv
